@@ rtl/gdp_pkg.sv @@
// Shared types, constants and helpers for the archive directory parser.
`timescale 1ns / 1ps

package gdp_pkg;

  localparam int NAME_FIELD_LEN = 12;
  localparam int ENTRY_BYTES    = NAME_FIELD_LEN + 4;
  localparam int HEADER_BYTES   = 16;
  localparam int SIG_BYTES      = 12;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TRUNCATED    = 3'd1,
    ST_BAD_SIG      = 3'd2,
    ST_DIR_OVERRUN  = 3'd3,
    ST_BAD_NAME     = 3'd4,
    ST_DATA_OVERRUN = 3'd5,
    ST_EMPTY_DIR    = 3'd6
  } gdp_status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_ENTRIES = 2'd1
  } gdp_phase_t;

  typedef struct packed {
    gdp_status_t  status;
    logic [31:0]  entry_index;
    logic [63:0]  name_low;
    logic [31:0]  name_high;
    logic [63:0]  key_low;
    logic [31:0]  key_high;
    logic [3:0]   name_length;
    logic [31:0]  data_size;
    logic [39:0]  entry_offset;
    logic [31:0]  dir_count;
    logic         last;
  } gdp_result_t;

  // Expected archive signature, one byte for each of the first twelve header positions.
  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] val;
    unique case (idx)
      4'd0:    val = 8'h4B;
      4'd1:    val = 8'h65;
      4'd2:    val = 8'h6E;
      4'd3:    val = 8'h53;
      4'd4:    val = 8'h69;
      4'd5:    val = 8'h6C;
      4'd6:    val = 8'h76;
      4'd7:    val = 8'h65;
      4'd8:    val = 8'h72;
      4'd9:    val = 8'h6D;
      4'd10:   val = 8'h61;
      4'd11:   val = 8'h6E;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] val;
    val = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
    return val;
  endfunction

endpackage

@@ rtl/gdp_if.sv @@
// Handshake channel interfaces: image bytes, configuration writes, results.
`timescale 1ns / 1ps

interface gdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface gdp_cfg_if;
  logic        valid;
  logic        ready;
  logic [39:0] image_len;
  modport source (output valid, output image_len, input ready);
  modport sink   (input valid, input image_len, output ready);
endinterface

interface gdp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] entry_index;
  logic [63:0] name_low;
  logic [31:0] name_high;
  logic [63:0] key_low;
  logic [31:0] key_high;
  logic [3:0]  name_length;
  logic [31:0] data_size;
  logic [39:0] entry_offset;
  logic [31:0] dir_count;
  logic        last;
  modport source (output valid, output status, output entry_index, output name_low,
                  output name_high, output key_low, output key_high, output name_length,
                  output data_size, output entry_offset, output dir_count,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_index, input name_low,
                  input name_high, input key_low, input key_high, input name_length,
                  input data_size, input entry_offset, input dir_count,
                  input last, output ready);
endinterface

@@ rtl/grp_directory_parser_core.sv @@
// Top level of the streaming archive directory parser.
// A result is registered in the result buffer when the byte that completes it is accepted.
// Throughput: one byte per cycle; a two-word result buffer lets bytes keep
// flowing while one result waits, and input stalls only when both words are held.
// Reset (synchronous, active high) restarts the parse at offset zero,
// empties the result buffer and clears the image length register.
`timescale 1ns / 1ps

module grp_directory_parser_core (
  input  logic         clk,
  input  logic         rst,
  gdp_cfg_if.sink      cfg,
  gdp_byte_if.sink     bytes,
  gdp_result_if.source results
);
  import gdp_pkg::*;

  logic [39:0] image_len;
  gdp_phase_t  phase;
  logic [3:0]  pos;
  logic        sig_ok;
  logic [31:0] count;
  logic [40:0] cursor;
  logic [31:0] entry;
  logic        nul_seen;
  logic [3:0]  name_len;
  logic        bad_char;
  logic [7:0]  name_buf [NAME_FIELD_LEN];
  logic [7:0]  key_buf [NAME_FIELD_LEN];
  logic [23:0] size_acc;

  logic        accept;
  logic        buf_full;
  logic [7:0]  b;
  logic        sig_ok_next;
  logic [4:0]  pos_inc;
  logic [31:0] count_full;
  logic [36:0] dir_end;
  logic [31:0] size_full;
  logic [40:0] data_end;
  logic        name_legal;
  logic        restart;
  logic        enter;
  logic        gen_valid;
  gdp_result_t gen;
  gdp_result_t out_word;

  assign b         = bytes.data_byte;
  assign bytes.ready = !buf_full;
  assign accept    = bytes.valid && !buf_full;
  assign cfg.ready = 1'b1;

  always_comb begin
    sig_ok_next = sig_ok && ((pos >= 4'(SIG_BYTES)) || (b == sig_byte(pos)));
    pos_inc     = {1'b0, pos} + 5'd1;
    count_full  = {b, count[23:0]};
    dir_end     = {1'b0, count_full, 4'b0000} + 37'(HEADER_BYTES);
    size_full   = {b, size_acc};
    data_end    = cursor + {9'b0, size_full};
    name_legal  = (name_len != 4'd0) && !bad_char
                  && !(name_len == 4'd1 && name_buf[0] == CH_DOT)
                  && !(name_len == 4'd2 && name_buf[0] == CH_DOT && name_buf[1] == CH_DOT);

    gen       = '0;
    gen_valid = 1'b0;
    restart   = 1'b0;
    enter     = 1'b0;

    if (accept) begin
      if (phase == PH_HEADER) begin
        priority if (pos_inc == 5'(SIG_BYTES) && !sig_ok_next
                     && image_len >= 40'(SIG_BYTES)) begin
          gen.status = ST_BAD_SIG;
          gen_valid  = 1'b1;
        end else if (pos_inc < 5'(HEADER_BYTES) && {35'b0, pos_inc} >= image_len) begin
          gen.status = ST_TRUNCATED;
          gen_valid  = 1'b1;
        end else if (pos_inc == 5'(HEADER_BYTES)) begin
          if ({3'b0, dir_end} > image_len) begin
            gen.status    = ST_DIR_OVERRUN;
            gen.dir_count = count_full;
            gen_valid     = 1'b1;
          end else if (count_full == 32'd0) begin
            gen.status = ST_EMPTY_DIR;
            gen_valid  = 1'b1;
          end else begin
            enter = 1'b1;
          end
        end else begin
          gen_valid = 1'b0;
        end
        gen.last = 1'b1;
        restart  = gen_valid;
      end else if (pos == 4'(ENTRY_BYTES - 1)) begin
        gen_valid = 1'b1;
        if (!name_legal) begin
          gen.status = ST_BAD_NAME;
        end else if (data_end > {1'b0, image_len}) begin
          gen.status = ST_DATA_OVERRUN;
        end else begin
          gen.status = ST_OK;
        end
        gen.entry_index  = entry;
        for (int i = 0; i < 8; i++) begin
          gen.name_low[8*i +: 8] = name_buf[i];
          gen.key_low[8*i +: 8]  = key_buf[i];
        end
        for (int i = 0; i < NAME_FIELD_LEN - 8; i++) begin
          gen.name_high[8*i +: 8] = name_buf[i + 8];
          gen.key_high[8*i +: 8]  = key_buf[i + 8];
        end
        gen.name_length  = name_len;
        gen.data_size    = size_full;
        gen.entry_offset = cursor[39:0];
        gen.dir_count    = count;
        gen.last         = (gen.status != ST_OK) || (entry + 32'd1 == count);
        restart          = gen.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_len <= '0;
    end else if (cfg.valid) begin
      image_len <= cfg.image_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && restart)) begin
      phase    <= PH_HEADER;
      pos      <= '0;
      sig_ok   <= 1'b1;
      count    <= '0;
      cursor   <= '0;
      entry    <= '0;
      nul_seen <= 1'b0;
      name_len <= '0;
      bad_char <= 1'b0;
    end else if (accept) begin
      pos <= pos_inc[3:0];
      if (phase == PH_HEADER) begin
        sig_ok <= sig_ok_next;
        if (pos >= 4'(SIG_BYTES)) begin
          count[8*pos[1:0] +: 8] <= b;
        end
        if (enter) begin
          phase  <= PH_ENTRIES;
          cursor <= {4'b0, dir_end};
          entry  <= '0;
        end
      end else if (pos < 4'(NAME_FIELD_LEN)) begin
        // The name ends at its first NUL; later bytes are ignored.
        if (!nul_seen) begin
          if (b == CH_NUL) begin
            nul_seen <= 1'b1;
          end else begin
            name_len <= name_len + 4'd1;
            if (b == CH_SLASH || b == CH_BSLASH) begin
              bad_char <= 1'b1;
            end
          end
        end
      end else if (pos == 4'(ENTRY_BYTES - 1)) begin
        entry    <= entry + 32'd1;
        cursor   <= data_end;
        nul_seen <= 1'b0;
        name_len <= '0;
        bad_char <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_ENTRIES) begin
      if (pos < 4'(NAME_FIELD_LEN)) begin
        name_buf[pos] <= nul_seen ? CH_NUL : b;
        key_buf[pos]  <= nul_seen ? CH_NUL : to_upper(b);
      end else if (pos != 4'(ENTRY_BYTES - 1)) begin
        size_acc[8*pos[1:0] +: 8] <= b;
      end
    end
  end

  gdp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (gen_valid),
    .push_data (gen),
    .full      (buf_full),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (out_word)
  );

  assign results.status       = out_word.status;
  assign results.entry_index  = out_word.entry_index;
  assign results.name_low     = out_word.name_low;
  assign results.name_high    = out_word.name_high;
  assign results.key_low      = out_word.key_low;
  assign results.key_high     = out_word.key_high;
  assign results.name_length  = out_word.name_length;
  assign results.data_size    = out_word.data_size;
  assign results.entry_offset = out_word.entry_offset;
  assign results.dir_count    = out_word.dir_count;
  assign results.last         = out_word.last;

  // The data cursor and entry counter only move once the directory is open.
  a_header_idle: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> (entry == 32'd0 && cursor == 41'd0))
    else $error("cursor or entry counter moved during header parsing");

  // While entries are parsed, the entry counter stays below the declared count.
  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ENTRIES |-> entry < count)
    else $error("entry index ran past the declared file count");

  // Any failing status ends the run.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (gen_valid && !gen.last) |-> gen.status == ST_OK)
    else $error("error result issued without ending the run");

  // A pushed result must find room in the buffer.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    gen_valid |-> !buf_full)
    else $error("result pushed into a full buffer");

endmodule

@@ rtl/gdp_out_buf.sv @@
// Two-word result buffer: an output register plus a skid register.
`timescale 1ns / 1ps

module gdp_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gdp_pkg::gdp_result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output gdp_pkg::gdp_result_t out_data
);
  import gdp_pkg::*;

  gdp_result_t main_word;
  gdp_result_t skid_word;
  logic        main_valid;
  logic        skid_valid;
  logic        pop;

  assign pop       = main_valid && out_ready;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // No push can arrive while the skid register is occupied.
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_word <= skid_word;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_word <= push_data;
      end else begin
        skid_word <= push_data;
      end
    end
  end

endmodule
